FILE: rtl/std_pkg.sv
package std_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = 22;

  localparam logic [3:0] OP_TICK   = 4'd0;
  localparam logic [3:0] OP_ATT_P  = 4'd1;
  localparam logic [3:0] OP_ATT_F  = 4'd2;
  localparam logic [3:0] OP_TRIG   = 4'd3;
  localparam logic [3:0] OP_ONE    = 4'd4;
  localparam logic [3:0] OP_RATE   = 4'd5;
  localparam logic [3:0] OP_DET_S  = 4'd6;
  localparam logic [3:0] OP_DET_H  = 4'd7;
  localparam logic [3:0] OP_FIND   = 4'd8;
  localparam logic [3:0] OP_READ   = 4'd9;

  localparam logic [1:0] SK_FLAG = 2'd0;
  localparam logic [1:0] SK_PER  = 2'd1;
  localparam logic [1:0] SK_ONE  = 2'd2;

  localparam logic [1:0] RK_FIRE = 2'd0;
  localparam logic [1:0] RK_ANS  = 2'd1;
  localparam logic [1:0] RK_NONE = 2'd2;

  // one slot entry, minus the active bit
  typedef struct packed {
    logic [1:0]    kind;
    logic          flag;
    logic [CW-1:0] cnt;
    logic [19:0]   reload;
    logic [15:0]   handler;
    logic [31:0]   data;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [SW-1:0] waddr;
    entry_t        wdata;
    logic [SW-1:0] raddr;
  } mem_req_t;
endpackage

FILE: rtl/slot_timer_event_dispatcher.sv
// Slot timer event dispatcher: a table of SLOTS event slots (flag, periodic
// or one-shot timer), each with a handler id and a user data word.
// Command channel: a word is taken at a clock edge where start is high and
// busy is low. Results leave on the result ports for one cycle each with
// valid high; last marks the final result of a command. The receiver cannot
// stall the block, so there is no backpressure path.
// Walk: every command walks the slot memory one slot per cycle (each slot is
// read, then modified and written back in the cycle after). busy stays high
// until the walk is over, so no new word is taken before the previous
// command's walk has ended.
// Tick fires are held one stage so that last can mark the final one.
// Answers and the empty-tick result come after the walk.
// Reset clears the active bits and the control state; slots never written
// read their timer fields as zero through per-slot written bits, so no
// clearing pass is needed. Handler and data are undefined until attached.
// Detach by handler and find stop at the first match; attach takes the
// first free slot, both decided during the walk.
module slot_timer_event_dispatcher import std_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation,
  input  logic [3:0]  slot,
  input  logic [15:0] handler_id,
  input  logic [31:0] user_data,
  input  logic [19:0] period_ms,
  input  logic [15:0] elapsed_ms,
  output logic        valid,
  output logic [1:0]  kind,
  output logic [3:0]  slot_out,
  output logic        found,
  output logic [15:0] handler_out,
  output logic [31:0] data_out,
  output logic        last
);
  // most negative countdown value, one bit wider than the counter
  localparam logic signed [CW:0] CNT_MIN = {2'b11, {(CW-1){1'b0}}};

  logic [SLOTS-1:0] active, wrt;
  logic [3:0]  op;
  logic [3:0]  s_in;
  logic [15:0] h_in;
  logic [31:0] d_in;
  logic [19:0] iv_in;
  logic [15:0] el_in;
  logic [SW:0] rcnt;          // read address counter
  logic        pv;            // entry at paddr readable this cycle
  logic [SW-1:0] paddr;
  logic        done_flag;     // first-match already taken
  logic [SW-1:0] res_slot;
  logic        res_found;
  logic [31:0] res_data;
  logic        fin;
  logic        fin_d;         // walk over, final result goes out
  // held fire, released by the next fire or at walk end
  logic        hv;
  logic [SW-1:0] hs;
  logic [15:0] hh;
  logic [31:0] hd;

  mem_req_t req;
  entry_t   rd, e, w;

  logic ok;
  logic hit_sel, fire, tick_fire;
  logic signed [CW:0] dec;
  logic signed [CW-1:0] csat;
  logic act_next, wr_en, match, take_free, find_hit;

  std_slot_ram u_ram (.clk(clk), .req(req), .rdata(rd));

  // fields of an entry never written read as zero timer state
  always_comb begin
    e = rd;
    if (!wrt[paddr]) begin
      e.kind = SK_FLAG; e.flag = 1'b0; e.cnt = '0; e.reload = '0;
    end
  end

  assign ok = (int'(s_in) < SLOTS);
  assign hit_sel = ok && (paddr == SW'(s_in));
  assign match = active[paddr] && (e.handler == h_in);
  assign take_free = (op == OP_ATT_P || op == OP_ATT_F) && !done_flag && !active[paddr];
  assign find_hit = (op == OP_FIND) && !done_flag && match && ok && (paddr >= SW'(s_in));
  assign tick_fire = pv && (op == OP_TICK) && fire;

  always_comb begin
    w = e; wr_en = 1'b0; fire = 1'b0; act_next = active[paddr];
    dec = $signed({e.cnt[CW-1], e.cnt}) - $signed((CW+1)'(el_in));
    csat = (dec < CNT_MIN) ? CNT_MIN[CW-1:0] : dec[CW-1:0];
    case (op)
      OP_TICK: if (active[paddr]) begin
        if (e.kind == SK_FLAG) begin
          if (e.flag) begin fire = 1'b1; w.flag = 1'b0; wr_en = 1'b1; end
        end else if (e.kind == SK_PER || e.kind == SK_ONE) begin
          wr_en = 1'b1; w.cnt = csat;
          if (csat <= 0) begin
            fire = 1'b1;
            if (e.kind == SK_ONE) begin w.kind = SK_FLAG; w.flag = 1'b0; end
            else w.cnt = csat + $signed({2'b00, e.reload});
          end
        end
      end
      OP_ATT_P, OP_ATT_F: if (take_free) begin
        wr_en = 1'b1; act_next = 1'b1;
        w.kind = (op == OP_ATT_P) ? SK_PER : SK_FLAG;
        w.handler = h_in; w.data = d_in; w.flag = 1'b0;
        if (op == OP_ATT_P) begin w.cnt = CW'(iv_in); w.reload = iv_in; end
      end
      OP_TRIG: if (hit_sel) begin wr_en = 1'b1; w.flag = 1'b1; end
      OP_ONE: if (hit_sel) begin
        wr_en = 1'b1; w.kind = SK_ONE; w.cnt = CW'(iv_in); w.reload = iv_in;
      end
      OP_RATE: if (hit_sel) begin
        wr_en = 1'b1; w.cnt = CW'(iv_in); w.reload = iv_in;
      end
      OP_DET_S: if (hit_sel) act_next = 1'b0;
      OP_DET_H: if (!done_flag && match) act_next = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    req.we = pv && wr_en;
    req.waddr = paddr;
    req.wdata = w;
    req.raddr = rcnt[SW-1:0];
  end

  assign fin = pv && (paddr == SW'(SLOTS-1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; active <= '0; wrt <= '0; pv <= 1'b0; rcnt <= '0;
      fin_d <= 1'b0;
    end else begin
      fin_d <= fin;
      if (start && !busy) begin
        busy <= 1'b1; rcnt <= '0; op <= operation; s_in <= slot;
        h_in <= handler_id; d_in <= user_data; iv_in <= period_ms;
        el_in <= elapsed_ms; done_flag <= 1'b0;
        res_slot <= '0; res_found <= 1'b0; res_data <= '0;
        pv <= 1'b0;
      end else if (busy) begin
        pv <= (rcnt < (SW+1)'(SLOTS));
        paddr <= rcnt[SW-1:0];
        if (rcnt < (SW+1)'(SLOTS)) rcnt <= rcnt + 1'b1;
        if (fin) busy <= 1'b0;
        if (pv) begin
          active[paddr] <= act_next;
          if (wr_en) wrt[paddr] <= 1'b1;
          if (take_free) begin
            done_flag <= 1'b1; res_slot <= paddr; res_found <= 1'b1;
          end
          if (op == OP_DET_H && !done_flag && match) done_flag <= 1'b1;
          if (find_hit) begin
            done_flag <= 1'b1; res_slot <= paddr; res_found <= 1'b1;
          end
          if (op == OP_READ && hit_sel) res_data <= e.data;
        end
      end
    end
  end

  // a new fire pushes out the held one with last low
  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0; valid <= 1'b0;
    end else begin
      valid <= (tick_fire && hv) || fin_d;
      if (tick_fire) hv <= 1'b1;
      else if (fin_d) hv <= 1'b0;
    end
    if (tick_fire) begin
      hs <= paddr; hh <= e.handler; hd <= e.data;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_d && op != OP_TICK) begin
      kind <= RK_ANS; slot_out <= 4'(res_slot); found <= res_found;
      handler_out <= '0; data_out <= res_data; last <= 1'b1;
    end else if (fin_d && !hv) begin
      kind <= RK_NONE; slot_out <= '0; found <= 1'b0;
      handler_out <= '0; data_out <= '0; last <= 1'b1;
    end else begin
      kind <= RK_FIRE; slot_out <= 4'(hs); found <= 1'b0;
      handler_out <= hh; data_out <= hd; last <= fin_d;
    end
  end

`ifndef SYNTH
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("command not taken");
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    pv |-> busy) else $error("walk outside a command");
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    fin_d |=> valid) else $error("no result at walk end");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (valid && kind == RK_NONE) |-> last) else $error("empty tick not last");
`endif
endmodule

FILE: rtl/std_slot_ram.sv
module std_slot_ram import std_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);
  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule
